// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the nibble writer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/clnw_pkg.sv =====
// ----------------------------------------------------------------------------
// clnw_pkg
// types, constants and digit helpers for the character lcd nibble writer
// ----------------------------------------------------------------------------
`default_nettype none

package clnw_pkg;

  typedef enum logic [2:0] {
    OP_CMD     = 3'd0,
    OP_DATA    = 3'd1,
    OP_NUMBER  = 3'd2,
    OP_CURSOR  = 3'd3,
    OP_DISPLAY = 3'd4,
    OP_ENTRY   = 3'd5
  } opcode_e;

  typedef enum logic {
    JOB_BYTE   = 1'b0,
    JOB_NUMBER = 1'b1
  } job_kind_e;

  typedef enum logic [2:0] {
    BK_IDLE     = 3'd0,
    BK_BYTE_HI  = 3'd1,
    BK_BYTE_LO  = 3'd2,
    BK_DIGIT_HI = 3'd3,
    BK_DIGIT_LO = 3'd4
  } bk_state_e;

  localparam logic [2:0] DISPLAY_RESET = 3'd4;
  localparam logic [1:0] ENTRY_RESET   = 2'd2;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] ROW_OFFSET    = 8'h40;
  localparam logic [7:0] CMD_DISPLAY   = 8'h08;
  localparam logic [7:0] CMD_ENTRY     = 8'h04;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [2:0] MAX_LEAD      = 3'd4;
  localparam logic [2:0] LAST_DIGIT    = 3'd4;

  // one queued unit of work for the back end
  typedef struct packed {
    job_kind_e   kind;
    logic        reg_select;
    logic [7:0]  byte_val;
    logic        adv;
    logic        set_cur;
    logic [5:0]  new_cur;
    logic [15:0] number;
    logic [2:0]  lead;
  } job_t;

  typedef struct packed {
    logic busy;
    logic load_last;
  } bk_status_t;

  function automatic logic [13:0] place_value(input logic [2:0] idx);
    logic [13:0] p;
    case (idx)
      3'd0:    p = 14'd10000;
      3'd1:    p = 14'd1000;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd10;
      default: p = 14'd1;
    endcase
    return p;
  endfunction

  // decimal digit of rem at place idx, rem known below ten places
  function automatic logic [3:0] digit_at(input logic [15:0] rem, input logic [2:0] idx);
    logic [3:0]  d;
    logic [16:0] p;
    p = {3'b000, place_value(idx)};
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({1'b0, rem} >= 17'(17'(k) * p)) d = 4'(k);
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/clnw_if.sv =====
// ----------------------------------------------------------------------------
// clnw channels
// valid/ready channels for operation items and nibble transfers
// ----------------------------------------------------------------------------
`default_nettype none

interface clnw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  byte_value;
  logic [15:0] number;
  logic [2:0]  lead_digits;
  logic [5:0]  column;
  logic [1:0]  row;
  logic [2:0]  bit_mask;
  logic        bit_set;

  modport source (
    output valid, opcode, byte_value, number, lead_digits, column, row, bit_mask,
           bit_set,
    input  ready
  );
  modport sink (
    input  valid, opcode, byte_value, number, lead_digits, column, row, bit_mask,
           bit_set,
    output ready
  );
endinterface

interface clnw_out_if;
  logic       valid;
  logic       ready;
  logic       reg_select;
  logic [3:0] nibble;
  logic       last;
  logic [7:0] cursor_pos;

  modport source (output valid, reg_select, nibble, last, cursor_pos, input ready);
  modport sink (input valid, reg_select, nibble, last, cursor_pos, output ready);
endinterface

`default_nettype wire

// ===== rtl/clnw_front.sv =====
// ----------------------------------------------------------------------------
// clnw_front
// accepts operations, keeps the mode flags and turns each defined opcode into a job
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_front (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  clnw_in_if.sink        in_i,
  input  wire logic      q_full_i,
  output clnw_pkg::job_t job_o,
  output logic           push_o
);

  logic [2:0] display_q, display_d;
  logic [1:0] entry_q, entry_d;
  logic       accept;
  logic       row_c;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign row_c      = in_i.row != 2'd0;

  always_comb begin
    display_d         = display_q;
    entry_d           = entry_q;
    push_o            = 1'b0;
    job_o.kind        = clnw_pkg::JOB_BYTE;
    job_o.reg_select  = 1'b0;
    job_o.byte_val    = in_i.byte_value;
    job_o.adv         = 1'b0;
    job_o.set_cur     = 1'b0;
    job_o.new_cur     = in_i.column;
    job_o.number      = in_i.number;
    job_o.lead        = (in_i.lead_digits > clnw_pkg::MAX_LEAD) ? clnw_pkg::MAX_LEAD
                                                                : in_i.lead_digits;
    case (clnw_pkg::opcode_e'(in_i.opcode))
      clnw_pkg::OP_CMD: begin
        push_o = accept;
      end
      clnw_pkg::OP_DATA: begin
        push_o           = accept;
        job_o.reg_select = 1'b1;
        job_o.adv        = 1'b1;
      end
      clnw_pkg::OP_NUMBER: begin
        push_o           = accept;
        job_o.kind       = clnw_pkg::JOB_NUMBER;
        job_o.reg_select = 1'b1;
      end
      clnw_pkg::OP_CURSOR: begin
        push_o         = accept;
        job_o.set_cur  = 1'b1;
        job_o.byte_val = clnw_pkg::CMD_SET_DDRAM | (row_c ? clnw_pkg::ROW_OFFSET : 8'h00)
                         | {2'b00, in_i.column};
      end
      clnw_pkg::OP_DISPLAY: begin
        push_o         = accept;
        display_d      = in_i.bit_set ? (display_q | in_i.bit_mask)
                                      : (display_q & ~in_i.bit_mask);
        job_o.byte_val = clnw_pkg::CMD_DISPLAY | {5'b00000, display_d};
        if (!accept) display_d = display_q;
      end
      clnw_pkg::OP_ENTRY: begin
        push_o         = accept;
        entry_d        = in_i.bit_set ? (entry_q | in_i.bit_mask[1:0])
                                      : (entry_q & ~in_i.bit_mask[1:0]);
        job_o.byte_val = clnw_pkg::CMD_ENTRY | {6'b000000, entry_d};
        if (!accept) entry_d = entry_q;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      display_q <= clnw_pkg::DISPLAY_RESET;
      entry_q   <= clnw_pkg::ENTRY_RESET;
    end else begin
      display_q <= display_d;
      entry_q   <= entry_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clnw_fifo.sv =====
// ----------------------------------------------------------------------------
// clnw_fifo
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire clnw_pkg::job_t job_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output clnw_pkg::job_t      job_o
);

  clnw_pkg::job_t mem_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/clnw_back.sv =====
// ----------------------------------------------------------------------------
// clnw_back
// splits jobs into nibble transfers, prints numbers digit by digit
// ----------------------------------------------------------------------------
`default_nettype none

module clnw_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire clnw_pkg::job_t  q_job_i,
  output logic                 pop_o,
  clnw_out_if.source           out_o,
  output clnw_pkg::bk_status_t stat_o
);

  clnw_pkg::bk_state_e state_q, state_d;
  clnw_pkg::job_t      job_q, job_d;
  logic [15:0]         rem_q, rem_d;
  logic [2:0]          idx_q, idx_d;
  logic                started_q, started_d;
  logic [7:0]          cursor_q, cursor_d;

  logic                out_valid_q;
  logic                out_rs_q, out_last_q;
  logic [3:0]          out_nib_q;
  logic [7:0]          out_cur_q;

  logic                load_ok, load, finish;
  logic                o_rs, o_last;
  logic [3:0]          o_nib;
  logic [7:0]          o_cur;
  logic [3:0]          digit;
  logic [7:0]          digit_char;
  logic [17:0]         digit_sub;
  logic                emit;

  assign load_ok    = !out_valid_q || out_o.ready;
  assign digit      = clnw_pkg::digit_at(rem_q, idx_q);
  assign digit_char = clnw_pkg::ASCII_ZERO + {4'b0000, digit};
  assign digit_sub  = {14'd0, digit} * {4'b0000, clnw_pkg::place_value(idx_q)};
  assign emit       = (digit != 4'd0) || started_q
                      || (({1'b0, idx_q} + {1'b0, job_q.lead}) >= {1'b0, clnw_pkg::LAST_DIGIT});

  always_comb begin
    state_d   = state_q;
    job_d     = job_q;
    rem_d     = rem_q;
    idx_d     = idx_q;
    started_d = started_q;
    cursor_d  = cursor_q;
    load      = 1'b0;
    finish    = 1'b0;
    pop_o     = 1'b0;
    o_rs      = job_q.reg_select;
    o_nib     = job_q.byte_val[7:4];
    o_last    = 1'b0;
    o_cur     = cursor_q;

    case (state_q)
      clnw_pkg::BK_IDLE: begin
        finish = 1'b1;
      end
      clnw_pkg::BK_BYTE_HI: begin
        if (load_ok) begin
          load    = 1'b1;
          state_d = clnw_pkg::BK_BYTE_LO;
        end
      end
      clnw_pkg::BK_BYTE_LO: begin
        if (load_ok) begin
          if (job_q.adv) cursor_d = cursor_q + 8'd1;
          if (job_q.set_cur) cursor_d = {2'b00, job_q.new_cur};
          load   = 1'b1;
          o_nib  = job_q.byte_val[3:0];
          o_last = 1'b1;
          o_cur  = cursor_d;
          finish = 1'b1;
        end
      end
      clnw_pkg::BK_DIGIT_HI: begin
        if (!emit) begin
          idx_d = idx_q + 3'd1;
        end else if (load_ok) begin
          load    = 1'b1;
          o_nib   = digit_char[7:4];
          state_d = clnw_pkg::BK_DIGIT_LO;
        end
      end
      clnw_pkg::BK_DIGIT_LO: begin
        if (load_ok) begin
          cursor_d  = cursor_q + 8'd1;
          rem_d     = rem_q - digit_sub[15:0];
          started_d = 1'b1;
          load      = 1'b1;
          o_nib     = digit_char[3:0];
          o_cur     = cursor_d;
          o_last    = idx_q == clnw_pkg::LAST_DIGIT;
          if (idx_q == clnw_pkg::LAST_DIGIT) begin
            finish = 1'b1;
          end else begin
            idx_d   = idx_q + 3'd1;
            state_d = clnw_pkg::BK_DIGIT_HI;
          end
        end
      end
      default: begin
        state_d = clnw_pkg::BK_IDLE;
      end
    endcase

    // pick up the next job as the current one ends
    if (finish) begin
      if (q_valid_i) begin
        pop_o     = 1'b1;
        job_d     = q_job_i;
        rem_d     = q_job_i.number;
        idx_d     = 3'd0;
        started_d = 1'b0;
        state_d   = (q_job_i.kind == clnw_pkg::JOB_NUMBER) ? clnw_pkg::BK_DIGIT_HI
                                                           : clnw_pkg::BK_BYTE_HI;
      end else begin
        state_d = clnw_pkg::BK_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= clnw_pkg::BK_IDLE;
      cursor_q    <= 8'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q     <= job_d;
    rem_q     <= rem_d;
    idx_q     <= idx_d;
    started_q <= started_d;
    if (load) begin
      out_rs_q   <= o_rs;
      out_nib_q  <= o_nib;
      out_last_q <= o_last;
      out_cur_q  <= o_cur;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.reg_select = out_rs_q;
  assign out_o.nibble     = out_nib_q;
  assign out_o.last       = out_last_q;
  assign out_o.cursor_pos = out_cur_q;

  assign stat_o.busy      = state_q != clnw_pkg::BK_IDLE;
  assign stat_o.load_last = load && o_last;

endmodule

`default_nettype wire

// ===== rtl/char_lcd_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer: 4-bit bus writer for a character lcd
// first nibble: the job is queued, popped by the back end, then held in the registered output stage
// throughput: back end sends 1 nibble/cycle while the output is ready; a blanked leading zero sends none
// reset: async low; cursor 0, display flags 4, entry flags 2, queue empty
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module char_lcd_nibble_writer (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  clnw_in_if.sink    in_i,
  clnw_out_if.source out_o
);

  // front end: classifies operations, owns display and entry flags
  clnw_pkg::job_t      fe_job;
  logic                fe_push;

  // queue status and head
  logic                q_full;
  logic                q_valid;
  logic                q_pop;
  clnw_pkg::job_t      q_job;

  // back end status, used for checking
  clnw_pkg::bk_status_t bk_stat;

  clnw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .job_o    (fe_job),
    .push_o   (fe_push)
  );

  // short queue lets the front keep taking transactions while the back stalls
  clnw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fe_push),
    .job_i   (fe_job),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_job)
  );

  // back end: nibble sequencing, digit extraction, cursor tracking,
  // registered output stage
  clnw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_job_i   (q_job),
    .pop_o     (q_pop),
    .out_o     (out_o),
    .stat_o    (bk_stat)
  );

  // unused opcodes are consumed without queueing work
  `ASSERT_RST(a_unused_op_no_push, clk_i, rst_ni,
              (in_i.valid && in_i.ready && in_i.opcode > clnw_pkg::OP_ENTRY) |-> !fe_push,
              "unused opcode queued a job")

  // back end never pops an empty queue
  `ASSERT_ALWAYS(a_pop_nonempty, clk_i, q_pop |-> q_valid, "pop from empty queue")

  // back end only goes idle right after loading a final nibble
  `ASSERT_RST(a_idle_after_last, clk_i, rst_ni,
              $fell(bk_stat.busy) |-> $past(bk_stat.load_last),
              "back end idled without final nibble")

endmodule

`default_nettype wire

// ===== dv/tb_char_lcd_nibble_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_writer
// drives lcd operations into the nibble writer, keeps a cycle-free model
// of its cursor and flag state and checks each nibble transaction in order;
// directed corner cases first, then random traffic under several stall patterns
// ----------------------------------------------------------------------------

module tb_char_lcd_nibble_writer;

  // opcodes the block has no use for; they must pass without any nibble
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // settle time after the last nibble, well past the block's latency
  localparam int unsigned SETTLE_CYCLES = 20;

  // one operation as presented on the input channel
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  byte_value;
    logic [15:0] number;
    logic [2:0]  lead_digits;
    logic [5:0]  column;
    logic [1:0]  row;
    logic [2:0]  bit_mask;
    logic        bit_set;
  } lcd_op_t;

  // one nibble transfer on the lcd bus side
  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
    logic [7:0] cursor_pos;
  } bus_xfer_t;

  logic clk_i;
  logic rst_ni;

  clnw_in_if  in_ch ();
  clnw_out_if out_ch ();

  char_lcd_nibble_writer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // shadow of the block's state, advanced once per accepted operation
  logic [7:0] model_cursor;
  logic [2:0] model_display;
  logic [1:0] model_entry;

  // nibbles still owed by the block, oldest first
  bus_xfer_t pending_xfers[$];

  int unsigned mismatch_count;

  // stall percentages for the current phase
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // expected nibble generation
  // ---------------------------------------------------------------------------

  // one byte becomes two nibbles; the cursor moves with the low nibble only,
  // so the high nibble reports the value from before
  task automatic queue_byte(ref bus_xfer_t xfers[$], input logic rs, input logic [7:0] b,
                            input logic adv, input logic set_cur, input logic [5:0] new_cur);
    bus_xfer_t x;
    x.reg_select = rs;
    x.nibble     = b[7:4];
    x.last       = 1'b0;
    x.cursor_pos = model_cursor;
    xfers.push_back(x);
    if (adv) model_cursor = model_cursor + 8'd1;
    if (set_cur) model_cursor = {2'b00, new_cur};
    x.nibble     = b[3:0];
    x.cursor_pos = model_cursor;
    xfers.push_back(x);
  endtask

  // work out every nibble an accepted operation causes and queue it
  task automatic predict_lcd_op(input lcd_op_t op);
    bus_xfer_t   xfers[$];
    int unsigned rest;
    int unsigned place;
    int unsigned digit;
    int unsigned min_lead;
    logic        started;
    logic [1:0]  row_clamped;
    rest    = op.number;
    place   = 10000;
    started = 1'b0;
    case (op.opcode)
      clnw_pkg::OP_CMD: begin
        queue_byte(xfers, 1'b0, op.byte_value, 1'b0, 1'b0, 6'd0);
      end
      clnw_pkg::OP_DATA: begin
        queue_byte(xfers, 1'b1, op.byte_value, 1'b1, 1'b0, 6'd0);
      end
      clnw_pkg::OP_NUMBER: begin
        // lead digit count saturates at four (MAX_LEAD), which pads to all five digits
        min_lead = (op.lead_digits > clnw_pkg::MAX_LEAD) ? clnw_pkg::MAX_LEAD
                                                          : op.lead_digits;
        for (int i = 0; i < 5; i++) begin
          digit = rest / place;
          rest  = rest % place;
          // blank leading zeros unless inside the minimum width or after a digit
          if (digit != 0 || started || (4 - i) <= min_lead) begin
            started = 1'b1;
            queue_byte(xfers, 1'b1, clnw_pkg::ASCII_ZERO + 8'(digit), 1'b1, 1'b0, 6'd0);
          end
          place = place / 10;
        end
      end
      clnw_pkg::OP_CURSOR: begin
        // rows past the second fold onto the second row
        row_clamped = (op.row > 2'd1) ? 2'd1 : op.row;
        queue_byte(xfers, 1'b0,
                   clnw_pkg::CMD_SET_DDRAM
                   | (8'(op.column) + clnw_pkg::ROW_OFFSET * 8'(row_clamped)),
                   1'b0, 1'b1, op.column);
      end
      clnw_pkg::OP_DISPLAY: begin
        if (op.bit_set) model_display = model_display | op.bit_mask;
        else model_display = model_display & ~op.bit_mask;
        queue_byte(xfers, 1'b0, clnw_pkg::CMD_DISPLAY | 8'(model_display), 1'b0, 1'b0, 6'd0);
      end
      clnw_pkg::OP_ENTRY: begin
        // only the two low mask bits reach the entry flags
        if (op.bit_set) model_entry = model_entry | op.bit_mask[1:0];
        else model_entry = model_entry & ~op.bit_mask[1:0];
        queue_byte(xfers, 1'b0, clnw_pkg::CMD_ENTRY | 8'(model_entry), 1'b0, 1'b0, 6'd0);
      end
      default: begin
        // spare opcodes: no nibbles, no state change
      end
    endcase
    if (xfers.size() > 0) xfers[xfers.size() - 1].last = 1'b1;
    foreach (xfers[i]) pending_xfers.push_back(xfers[i]);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random backpressure and in-order checking
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_xfers
    bus_xfer_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_xfers.size() == 0) begin
        $display("%0t: unexpected transaction rs=%0d nibble=%h last=%0d cursor=%0d",
                 $time, out_ch.reg_select, out_ch.nibble, out_ch.last, out_ch.cursor_pos);
        mismatch_count++;
      end else begin
        want = pending_xfers.pop_front();
        if (out_ch.reg_select !== want.reg_select || out_ch.nibble !== want.nibble ||
            out_ch.last !== want.last || out_ch.cursor_pos !== want.cursor_pos) begin
          $display("%0t: mismatch expected rs=%0d nibble=%h last=%0d cursor=%0d",
                   $time, want.reg_select, want.nibble, want.last, want.cursor_pos);
          $display("%0t:          actual   rs=%0d nibble=%h last=%0d cursor=%0d",
                   $time, out_ch.reg_select, out_ch.nibble, out_ch.last, out_ch.cursor_pos);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one operation, with random idle cycles ahead of it, and predict
  // its nibbles at the edge where the transaction completes; valid stays high
  // afterwards so back-to-back operations need no extra assignment
  task automatic send_op(input lcd_op_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op.opcode;
    in_ch.byte_value  <= op.byte_value;
    in_ch.number      <= op.number;
    in_ch.lead_digits <= op.lead_digits;
    in_ch.column      <= op.column;
    in_ch.row         <= op.row;
    in_ch.bit_mask    <= op.bit_mask;
    in_ch.bit_set     <= op.bit_set;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_lcd_op(op);
  endtask

  // hold the sender off until every owed nibble has come out
  task automatic drain_pending();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_xfers.size() != 0) @(posedge clk_i);
  endtask

  function automatic lcd_op_t make_op(input logic [2:0] opcode, input logic [7:0] byte_value,
                                      input logic [15:0] number, input logic [2:0] lead_digits,
                                      input logic [5:0] column, input logic [1:0] row,
                                      input logic [2:0] bit_mask, input logic bit_set);
    lcd_op_t op;
    op.opcode      = opcode;
    op.byte_value  = byte_value;
    op.number      = number;
    op.lead_digits = lead_digits;
    op.column      = column;
    op.row         = row;
    op.bit_mask    = bit_mask;
    op.bit_set     = bit_set;
    return op;
  endfunction

  // random operation; every field is random so that unused fields toggle too
  function automatic lcd_op_t rand_lcd_op();
    lcd_op_t     op;
    int unsigned pick;
    op.byte_value  = 8'($urandom);
    op.lead_digits = 3'($urandom);
    op.column      = 6'($urandom);
    op.row         = 2'($urandom);
    op.bit_mask    = 3'($urandom);
    op.bit_set     = 1'($urandom);
    // mostly short numbers so that blanking and width padding get exercised
    case ($urandom_range(3))
      0:       op.number = 16'($urandom_range(9));
      1:       op.number = 16'($urandom_range(999));
      2:       op.number = 16'($urandom_range(9999));
      default: op.number = 16'($urandom);
    endcase
    pick = $urandom_range(99);
    if (pick < 12) op.opcode = clnw_pkg::OP_CMD;
    else if (pick < 37) op.opcode = clnw_pkg::OP_DATA;
    else if (pick < 62) op.opcode = clnw_pkg::OP_NUMBER;
    else if (pick < 72) op.opcode = clnw_pkg::OP_CURSOR;
    else if (pick < 82) op.opcode = clnw_pkg::OP_DISPLAY;
    else if (pick < 92) op.opcode = clnw_pkg::OP_ENTRY;
    else op.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return op;
  endfunction

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // raw command and data bytes at the byte extremes
  task automatic test_byte_ops();
    send_op(make_op(clnw_pkg::OP_CMD, 8'h00, '0, '0, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_CMD, 8'hff, '0, '0, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_DATA, 8'h00, '0, '0, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_DATA, 8'hff, '0, '0, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_DATA, 8'h5a, '0, '0, '0, '0, '0, 1'b0));
  endtask

  // decimal printing: zero, full width, inner zeros, padding, lead saturation
  task automatic test_numbers();
    send_op(make_op(clnw_pkg::OP_NUMBER, '0, 16'd0, 3'd0, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_NUMBER, '0, 16'd0, 3'd7, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_NUMBER, '0, 16'd65535, 3'd0, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_NUMBER, '0, 16'd10000, 3'd0, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_NUMBER, '0, 16'd7, 3'd2, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_NUMBER, '0, 16'd100, 3'd5, '0, '0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_NUMBER, '0, 16'd9, 3'd4, '0, '0, '0, 1'b0));
  endtask

  // set cursor at the column extremes, with in-range and clamped rows
  task automatic test_cursor();
    send_op(make_op(clnw_pkg::OP_CURSOR, '0, '0, '0, 6'd0, 2'd0, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_CURSOR, '0, '0, '0, 6'd63, 2'd3, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_CURSOR, '0, '0, '0, 6'd5, 2'd2, '0, 1'b0));
    send_op(make_op(clnw_pkg::OP_CURSOR, '0, '0, '0, 6'd10, 2'd1, '0, 1'b0));
  endtask

  // display and entry flag updates, including the ignored entry mask bit
  task automatic test_flags();
    send_op(make_op(clnw_pkg::OP_DISPLAY, '0, '0, '0, '0, '0, 3'd7, 1'b1));
    send_op(make_op(clnw_pkg::OP_DISPLAY, '0, '0, '0, '0, '0, 3'd2, 1'b0));
    send_op(make_op(clnw_pkg::OP_DISPLAY, '0, '0, '0, '0, '0, 3'd0, 1'b1));
    send_op(make_op(clnw_pkg::OP_ENTRY, '0, '0, '0, '0, '0, 3'd7, 1'b1));
    send_op(make_op(clnw_pkg::OP_ENTRY, '0, '0, '0, '0, '0, 3'd3, 1'b0));
    send_op(make_op(clnw_pkg::OP_ENTRY, '0, '0, '0, '0, '0, 3'd1, 1'b1));
  endtask

  // spare opcodes must be swallowed without any nibble
  task automatic test_spare_ops();
    send_op(make_op(OP_SPARE_LO, 8'hff, 16'hffff, 3'd7, 6'd63, 2'd3, 3'd7, 1'b1));
    send_op(make_op(OP_SPARE_HI, 8'h00, 16'h0000, 3'd0, 6'd0, 2'd0, 3'd0, 1'b0));
    send_op(make_op(clnw_pkg::OP_DATA, 8'h41, '0, '0, '0, '0, '0, 1'b0));
  endtask

  // long run of cursor-advancing writes from column 63 so the count wraps
  task automatic test_cursor_wrap();
    lcd_op_t op;
    send_op(make_op(clnw_pkg::OP_CURSOR, '0, '0, '0, 6'd63, 2'd0, '0, 1'b0));
    for (int n = 0; n < 55; n++) begin
      op = rand_lcd_op();
      if ($urandom_range(99) < 80) begin
        op.opcode      = clnw_pkg::OP_NUMBER;
        op.lead_digits = clnw_pkg::MAX_LEAD;
      end else begin
        op.opcode = clnw_pkg::OP_DATA;
      end
      send_op(op);
    end
  endtask

  // random mix; the sender holds off once mid-phase until the block drains
  task automatic test_random(input int unsigned count);
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) drain_pending();
      send_op(rand_lcd_op());
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni            = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = '0;
    in_ch.byte_value  = '0;
    in_ch.number      = '0;
    in_ch.lead_digits = '0;
    in_ch.column      = '0;
    in_ch.row         = '0;
    in_ch.bit_mask    = '0;
    in_ch.bit_set     = 1'b0;
    out_ch.ready      = 1'b0;
    mismatch_count    = 0;
    model_cursor      = 8'd0;
    model_display     = clnw_pkg::DISPLAY_RESET;
    model_entry       = clnw_pkg::ENTRY_RESET;
    set_idle(0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at full rate
    test_byte_ops();
    test_numbers();
    test_cursor();
    test_flags();
    test_spare_ops();
    drain_pending();

    // random part, one phase per stall pattern
    set_idle(0, 0);
    test_random(90);
    drain_pending();
    set_idle(71, 0);
    test_random(85);
    drain_pending();
    set_idle(0, 71);
    test_random(85);
    drain_pending();
    set_idle(21, 21);
    test_cursor_wrap();
    test_random(85);

    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (pending_xfers.size() != 0) begin
      $display("%0t: %0d expected transactions never arrived", $time, pending_xfers.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("char_lcd_nibble_writer test passed");
    end else begin
      $display("char_lcd_nibble_writer test failed");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("char_lcd_nibble_writer test failed");
    $finish;
  end

endmodule
